// File: rtl/lbc_pkg.sv
`default_nettype none

package lbc_pkg;

  // LED drive levels
  localparam logic [9:0] LevelFull = 10'd1023;
  localparam logic [9:0] LevelDark = 10'd0;

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_OFF   = 2'd1,
    CMD_ON    = 2'd2,
    CMD_BLINK = 2'd3
  } cmd_e;

  // Operating mode
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  // Blink code phase
  typedef enum logic {
    PHASE_INTERVAL = 1'b0,
    PHASE_BLINKING = 1'b1
  } phase_e;

  // One request as held in the input stage
  typedef struct packed {
    cmd_e        command;
    logic [31:0] now_ms;
    logic [15:0] half_period_ms;
    logic [15:0] pause_ms;
    logic [7:0]  blink_target;
  } lbc_item_t;

  // One result as held in the output stage
  typedef struct packed {
    logic [9:0] level;
    logic       level_written;
    mode_e      mode;
    phase_e     blink_phase;
  } lbc_result_t;

endpackage

`default_nettype wire

// File: rtl/led_blink_code_controller.sv
// A request is registered in the input stage, then in the output stage that drives m_axis.
// Throughput: one request per cycle unless the output stalls; input and output stages
// each hold one request and the input stage refills while the output stage drains.
// Reset (rst_ni low, asynchronous): LED dark, mode off, interval phase,
// stored settings and time stamps zero, both stages empty.
`default_nettype none

module led_blink_code_controller import lbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [31:0] now_ms, [47:32] half_period_ms, [63:48] pause_ms, [71:64] blink_target
  input  wire logic [71:0] s_axis_tdata_i,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [9:0] level, [10] level_written, [12:11] mode, [13] blink_phase, [15:14] zero
  output      logic [15:0] m_axis_tdata_o
);

  logic        in_valid_q;
  lbc_item_t   in_item_q;
  logic        out_valid_q;
  lbc_result_t out_result_q;
  lbc_result_t result;
  logic        advance;

  // Move a request forward when the output stage is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.command        <= cmd_e'(s_axis_tuser_i);
      in_item_q.now_ms         <= s_axis_tdata_i[31:0];
      in_item_q.half_period_ms <= s_axis_tdata_i[47:32];
      in_item_q.pause_ms       <= s_axis_tdata_i[63:48];
      in_item_q.blink_target   <= s_axis_tdata_i[71:64];
    end
  end

  lbc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .result_o  (result)
  );

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_result_q.blink_phase, out_result_q.mode,
                            out_result_q.level_written, out_result_q.level};

endmodule

`default_nettype wire

// File: rtl/lbc_core.sv
`default_nettype none

module lbc_core import lbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire lbc_item_t   item_i,
  output lbc_result_t      result_o
);

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic        lit_q, lit_d;
  logic [7:0]  blinks_q, blinks_d;
  logic [31:0] toggle_stamp_q, toggle_stamp_d;
  logic [31:0] pause_stamp_q, pause_stamp_d;
  logic [15:0] half_period_q, half_period_d;
  logic [15:0] pause_q, pause_d;
  logic [7:0]  target_q, target_d;
  logic [9:0]  level_q, level_d;
  logic        wrote;

  logic [31:0] toggle_elapsed;
  logic [31:0] pause_elapsed;
  logic        toggle_due;
  logic        pause_due;
  logic [7:0]  blinks_inc;

  // Wrap-safe elapsed time since the last toggle and since the interval phase began
  assign toggle_elapsed = item_i.now_ms - toggle_stamp_q;
  assign pause_elapsed  = item_i.now_ms - pause_stamp_q;
  assign toggle_due     = toggle_elapsed >= {16'd0, half_period_q};
  assign pause_due      = pause_elapsed >= {16'd0, pause_q};
  assign blinks_inc     = blinks_q + 8'd1;

  // Next state for the request in the input stage
  always_comb begin
    mode_d         = mode_q;
    phase_d        = phase_q;
    lit_d          = lit_q;
    blinks_d       = blinks_q;
    toggle_stamp_d = toggle_stamp_q;
    pause_stamp_d  = pause_stamp_q;
    half_period_d  = half_period_q;
    pause_d        = pause_q;
    target_d       = target_q;
    level_d        = level_q;
    wrote          = 1'b0;
    case (item_i.command)
      CMD_OFF: begin
        mode_d  = MODE_OFF;
        level_d = LevelDark;
        wrote   = 1'b1;
      end
      CMD_ON: begin
        mode_d  = MODE_ON;
        level_d = LevelFull;
        wrote   = 1'b1;
      end
      CMD_BLINK: begin
        // Merge nonzero settings and restart dark in the interval phase
        mode_d = MODE_BLINK;
        if (item_i.half_period_ms != 16'd0) half_period_d = item_i.half_period_ms;
        if (item_i.pause_ms != 16'd0) pause_d = item_i.pause_ms;
        if (item_i.blink_target != 8'd0) target_d = item_i.blink_target;
        blinks_d      = 8'd0;
        phase_d       = PHASE_INTERVAL;
        pause_stamp_d = item_i.now_ms;
        lit_d         = 1'b0;
        level_d       = LevelDark;
        wrote         = 1'b1;
      end
      default: begin
        // Tick: only acts in blink code mode
        if (mode_q == MODE_BLINK) begin
          if (phase_q == PHASE_BLINKING) begin
            if (toggle_due) begin
              toggle_stamp_d = item_i.now_ms;
              lit_d          = !lit_q;
              level_d        = lit_q ? LevelDark : LevelFull;
              wrote          = 1'b1;
              // Count the dark edge and close the group when done, leaving blink mode if a target is set
              if (lit_q) begin
                blinks_d = blinks_inc;
                if (target_q == 8'd0 || blinks_inc >= target_q) begin
                  phase_d       = PHASE_INTERVAL;
                  pause_stamp_d = item_i.now_ms;
                  blinks_d      = 8'd0;
                  if (target_q != 8'd0) begin
                    mode_d  = MODE_OFF;
                    level_d = LevelDark;
                  end
                end
              end
            end
          end else if (pause_due) begin
            phase_d        = PHASE_BLINKING;
            toggle_stamp_d = item_i.now_ms;
          end
        end
      end
    endcase
  end

  // Result of this request
  assign result_o.level         = level_d;
  assign result_o.level_written = wrote;
  assign result_o.mode          = mode_d;
  assign result_o.blink_phase   = phase_d;

  // Commit state as the request moves to the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_OFF;
      phase_q        <= PHASE_INTERVAL;
      lit_q          <= 1'b0;
      blinks_q       <= 8'd0;
      toggle_stamp_q <= 32'd0;
      pause_stamp_q  <= 32'd0;
      half_period_q  <= 16'd0;
      pause_q        <= 16'd0;
      target_q       <= 8'd0;
      level_q        <= LevelDark;
    end else if (advance_i) begin
      mode_q         <= mode_d;
      phase_q        <= phase_d;
      lit_q          <= lit_d;
      blinks_q       <= blinks_d;
      toggle_stamp_q <= toggle_stamp_d;
      pause_stamp_q  <= pause_stamp_d;
      half_period_q  <= half_period_d;
      pause_q        <= pause_d;
      target_q       <= target_d;
      level_q        <= level_d;
    end
  end

endmodule

`default_nettype wire
